@@ hw/rtl/sid_pkg.sv @@
// Shared types for the segment intersection with depth block.
`default_nettype none

package sid_pkg;

    typedef enum logic [1:0] {
        ORI_COL,
        ORI_POS,
        ORI_NEG
    } orient_t;

endpackage

`default_nettype wire

@@ hw/rtl/segment_intersection_with_depth_top.sv @@
// Top level: segment intersection with interpolated depth.
// Path: geometry front end, x/y dividers, depth setup, depth divider, output register.
// Throughput: one transaction per cycle; the whole pipeline holds while the output waits.
// Cost sits in the three divider chains: one stage per quotient bit.
// Reset: rst_n clears all valid bits; no result is pending after reset.
`default_nettype none

module segment_intersection_with_depth_top #(
    parameter int COORD_BITS = 13,
    parameter int DEPTH_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [COORD_BITS-1:0]   a_start_x,
    input  wire logic signed [COORD_BITS-1:0]   a_start_y,
    input  wire logic signed [DEPTH_BITS-1:0]   a_start_z,
    input  wire logic signed [COORD_BITS-1:0]   a_end_x,
    input  wire logic signed [COORD_BITS-1:0]   a_end_y,
    input  wire logic signed [DEPTH_BITS-1:0]   a_end_z,
    input  wire logic signed [COORD_BITS-1:0]   b_start_x,
    input  wire logic signed [COORD_BITS-1:0]   b_start_y,
    input  wire logic signed [COORD_BITS-1:0]   b_end_x,
    input  wire logic signed [COORD_BITS-1:0]   b_end_y,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                hit,
    output logic signed [COORD_BITS-1:0]        cross_x,
    output logic signed [COORD_BITS-1:0]        cross_y,
    output logic signed [DEPTH_BITS-1:0]        cross_z
);
    localparam int C   = COORD_BITS;
    localparam int D   = DEPTH_BITS;
    localparam int NXW = 3 * C + 5;
    localparam int DTW = 2 * C + 3;
    localparam int XSW = 1 + 2 * C + 2 * D;
    localparam int ZNW = D + C + 3;
    localparam int ZSW = 2 + 2 * C + D;
    localparam int ZS  = D + 3;

    logic out_valid_reg;
    logic en;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    logic                  g_vld;
    logic                  g_ok;
    logic signed [NXW-1:0] g_nx;
    logic signed [NXW-1:0] g_ny;
    logic signed [DTW-1:0] g_det;
    logic signed [C-1:0]   g_p1x;
    logic signed [C-1:0]   g_q1x;
    logic signed [D-1:0]   g_z0;
    logic signed [D-1:0]   g_z1;

    sid_geom #(
        .C (C),
        .D (D)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (in_valid),
        .a_start_x (a_start_x),
        .a_start_y (a_start_y),
        .a_start_z (a_start_z),
        .a_end_x   (a_end_x),
        .a_end_y   (a_end_y),
        .a_end_z   (a_end_z),
        .b_start_x (b_start_x),
        .b_start_y (b_start_y),
        .b_end_x   (b_end_x),
        .b_end_y   (b_end_y),
        .out_vld   (g_vld),
        .ok        (g_ok),
        .num_x     (g_nx),
        .num_y     (g_ny),
        .det       (g_det),
        .p1x       (g_p1x),
        .q1x       (g_q1x),
        .z0        (g_z0),
        .z1        (g_z1)
    );

    logic                  xd_vld;
    logic signed [C:0]     xd_q;
    logic [XSW-1:0]        xd_side;
    logic                  yd_vld;
    logic signed [C:0]     yd_q;
    logic                  yd_ok;

    sid_div #(
        .NW (NXW),
        .DW (DTW),
        .QW (C),
        .SW (XSW)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (g_vld),
        .num      (g_nx),
        .den      (g_det),
        .side_in  ({g_ok, g_p1x, g_q1x, g_z0, g_z1}),
        .out_vld  (xd_vld),
        .quo      (xd_q),
        .side_out (xd_side)
    );

    sid_div #(
        .NW (NXW),
        .DW (DTW),
        .QW (C),
        .SW (1)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (g_vld),
        .num      (g_ny),
        .den      (g_det),
        .side_in  (g_ok),
        .out_vld  (yd_vld),
        .quo      (yd_q),
        .side_out (yd_ok)
    );

    logic                  x_ok;
    logic signed [C-1:0]   x_p1x;
    logic signed [C-1:0]   x_q1x;
    logic signed [D-1:0]   x_z0;
    logic signed [D-1:0]   x_z1;
    logic signed [C-1:0]   xc;
    logic signed [C-1:0]   yc;

    assign {x_ok, x_p1x, x_q1x, x_z0, x_z1} = xd_side;

    always_comb
    begin
        if (xd_q[C] != xd_q[C-1])
        begin
            xc = xd_q[C] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
        end
        else
        begin
            xc = xd_q[C-1:0];
        end
        if (yd_q[C] != yd_q[C-1])
        begin
            yc = yd_q[C] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
        end
        else
        begin
            yc = yd_q[C-1:0];
        end
    end

    // depth setup
    logic                  z1_vld_reg;
    logic                  z1_ok_reg;
    logic                  z1_use_reg;
    logic signed [D:0]     z1_dz_reg;
    logic signed [C+1:0]   z1_dx_reg;
    logic signed [C:0]     z1_den_reg;
    logic signed [C-1:0]   z1_x_reg;
    logic signed [C-1:0]   z1_y_reg;
    logic signed [D-1:0]   z1_z0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            z1_vld_reg <= xd_vld && yd_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z1_ok_reg  <= x_ok && yd_ok;
            z1_use_reg <= (x_z0 == x_z1) || (x_q1x == x_p1x);
            z1_dz_reg  <= x_z1 - x_z0;
            z1_dx_reg  <= xd_q - x_p1x;
            z1_den_reg <= x_q1x - x_p1x;
            z1_x_reg   <= xc;
            z1_y_reg   <= yc;
            z1_z0_reg  <= x_z0;
        end
    end

    logic                  z2_vld_reg;
    logic signed [ZNW-1:0] z2_prod_reg;
    logic signed [C:0]     z2_den_reg;
    logic [ZSW-1:0]        z2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            z2_vld_reg <= z1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z2_prod_reg <= z1_dz_reg * z1_dx_reg;
            z2_den_reg  <= z1_den_reg;
            z2_side_reg <= {z1_ok_reg, z1_use_reg, z1_x_reg, z1_y_reg, z1_z0_reg};
        end
    end

    logic                  zd_vld;
    logic signed [D+1:0]   zd_q;
    logic [ZSW-1:0]        zd_side;

    sid_div #(
        .NW (ZNW),
        .DW (C + 1),
        .QW (D + 1),
        .SW (ZSW)
    ) u_div_z (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (z2_vld_reg),
        .num      (z2_prod_reg),
        .den      (z2_den_reg),
        .side_in  (z2_side_reg),
        .out_vld  (zd_vld),
        .quo      (zd_q),
        .side_out (zd_side)
    );

    logic                  f_ok;
    logic                  f_use;
    logic signed [C-1:0]   f_x;
    logic signed [C-1:0]   f_y;
    logic signed [D-1:0]   f_z0;
    logic signed [ZS-1:0]  z0_ext;
    logic signed [ZS-1:0]  zsum;
    logic signed [D-1:0]   zsat;

    assign {f_ok, f_use, f_x, f_y, f_z0} = zd_side;

    always_comb
    begin
        z0_ext = ZS'(f_z0);
        zsum   = f_use ? z0_ext : z0_ext + ZS'(zd_q);
        if ((&zsum[ZS-1:D-1]) || !(|zsum[ZS-1:D-1]))
        begin
            zsat = zsum[D-1:0];
        end
        else
        begin
            zsat = zsum[ZS-1] ? {1'b1, {(D-1){1'b0}}} : {1'b0, {(D-1){1'b1}}};
        end
    end

    logic                  hit_reg;
    logic signed [C-1:0]   cross_x_reg;
    logic signed [C-1:0]   cross_y_reg;
    logic signed [D-1:0]   cross_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= zd_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg     <= f_ok;
            cross_x_reg <= f_ok ? f_x : '0;
            cross_y_reg <= f_ok ? f_y : '0;
            cross_z_reg <= f_ok ? zsat : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign cross_x   = cross_x_reg;
    assign cross_y   = cross_y_reg;
    assign cross_z   = cross_z_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sid_geom.sv @@
// Geometry front end: orientation tests, touch decision and Cramer numerators.
`default_nettype none

module sid_geom #(
    parameter int C = 13,
    parameter int D = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_vld,
    input  wire logic signed [C-1:0]   a_start_x,
    input  wire logic signed [C-1:0]   a_start_y,
    input  wire logic signed [D-1:0]   a_start_z,
    input  wire logic signed [C-1:0]   a_end_x,
    input  wire logic signed [C-1:0]   a_end_y,
    input  wire logic signed [D-1:0]   a_end_z,
    input  wire logic signed [C-1:0]   b_start_x,
    input  wire logic signed [C-1:0]   b_start_y,
    input  wire logic signed [C-1:0]   b_end_x,
    input  wire logic signed [C-1:0]   b_end_y,
    output logic                       out_vld,
    output logic                       ok,
    output logic signed [3*C+4:0]      num_x,
    output logic signed [3*C+4:0]      num_y,
    output logic signed [2*C+2:0]      det,
    output logic signed [C-1:0]        p1x,
    output logic signed [C-1:0]        q1x,
    output logic signed [D-1:0]        z0,
    output logic signed [D-1:0]        z1
);
    import sid_pkg::*;

    localparam int EW = C + 1;
    localparam int PW = 2 * C + 2;
    localparam int VW = 2 * C + 3;
    localparam int MW = 3 * C + 4;
    localparam int NW = 3 * C + 5;

    function automatic logic in_box(
        input logic signed [C-1:0] px,
        input logic signed [C-1:0] py,
        input logic signed [C-1:0] qx,
        input logic signed [C-1:0] qy,
        input logic signed [C-1:0] rx,
        input logic signed [C-1:0] ry
    );
        in_box = (qx <= px || qx <= rx) && (qx >= px || qx >= rx) &&
                 (qy <= py || qy <= ry) && (qy >= py || qy >= ry);
    endfunction

    // stage 1
    logic                  vld1_reg;
    logic signed [EW-1:0]  ab_reg [1:3][4];
    logic signed [EW-1:0]  ey_reg [4];
    logic signed [EW-1:0]  ex_reg [4];
    logic signed [EW-1:0]  fx_reg [4];
    logic signed [EW-1:0]  fy_reg [4];
    logic signed [C-1:0]   pt_reg [1:3][8];
    logic signed [D-1:0]   zz_reg [1:5][2];
    logic signed [C-1:0]   px_reg [4:5][2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ab_reg[1][0] <= a_end_y - a_start_y;
            ab_reg[1][1] <= a_start_x - a_end_x;
            ab_reg[1][2] <= b_end_y - b_start_y;
            ab_reg[1][3] <= b_start_x - b_end_x;
            ey_reg[0] <= a_end_y - a_start_y;
            ex_reg[0] <= a_end_x - a_start_x;
            fx_reg[0] <= b_start_x - a_end_x;
            fy_reg[0] <= b_start_y - a_end_y;
            ey_reg[1] <= a_end_y - a_start_y;
            ex_reg[1] <= a_end_x - a_start_x;
            fx_reg[1] <= b_end_x - a_end_x;
            fy_reg[1] <= b_end_y - a_end_y;
            ey_reg[2] <= b_end_y - b_start_y;
            ex_reg[2] <= b_end_x - b_start_x;
            fx_reg[2] <= a_start_x - b_end_x;
            fy_reg[2] <= a_start_y - b_end_y;
            ey_reg[3] <= b_end_y - b_start_y;
            ex_reg[3] <= b_end_x - b_start_x;
            fx_reg[3] <= a_end_x - b_end_x;
            fy_reg[3] <= a_end_y - b_end_y;
            pt_reg[1][0] <= a_start_x;
            pt_reg[1][1] <= a_start_y;
            pt_reg[1][2] <= a_end_x;
            pt_reg[1][3] <= a_end_y;
            pt_reg[1][4] <= b_start_x;
            pt_reg[1][5] <= b_start_y;
            pt_reg[1][6] <= b_end_x;
            pt_reg[1][7] <= b_end_y;
            zz_reg[1][0] <= a_start_z;
            zz_reg[1][1] <= a_end_z;
        end
    end

    // stage 2
    logic                  vld2_reg;
    logic signed [PW-1:0]  tpa_reg [4];
    logic signed [PW-1:0]  tpb_reg [4];
    logic signed [PW-1:0]  m_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                tpa_reg[k] <= ey_reg[k] * fx_reg[k];
                tpb_reg[k] <= ex_reg[k] * fy_reg[k];
            end
            m_reg[0] <= ab_reg[1][0] * pt_reg[1][0];
            m_reg[1] <= ab_reg[1][1] * pt_reg[1][1];
            m_reg[2] <= ab_reg[1][2] * pt_reg[1][4];
            m_reg[3] <= ab_reg[1][3] * pt_reg[1][5];
            m_reg[4] <= ab_reg[1][0] * ab_reg[1][3];
            m_reg[5] <= ab_reg[1][2] * ab_reg[1][1];
            ab_reg[2] <= ab_reg[1];
            pt_reg[2] <= pt_reg[1];
            zz_reg[2] <= zz_reg[1];
        end
    end

    // stage 3
    logic signed [VW-1:0]  v_turn [4];
    orient_t               ori [4];
    logic                  touch;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            v_turn[k] = tpa_reg[k] - tpb_reg[k];
            if (v_turn[k] == '0)
            begin
                ori[k] = ORI_COL;
            end
            else if (!v_turn[k][VW-1])
            begin
                ori[k] = ORI_POS;
            end
            else
            begin
                ori[k] = ORI_NEG;
            end
        end
        touch = (ori[0] != ori[1] && ori[2] != ori[3]) ||
                (ori[0] == ORI_COL && in_box(pt_reg[2][0], pt_reg[2][1], pt_reg[2][4],
                                             pt_reg[2][5], pt_reg[2][2], pt_reg[2][3])) ||
                (ori[1] == ORI_COL && in_box(pt_reg[2][0], pt_reg[2][1], pt_reg[2][6],
                                             pt_reg[2][7], pt_reg[2][2], pt_reg[2][3])) ||
                (ori[2] == ORI_COL && in_box(pt_reg[2][4], pt_reg[2][5], pt_reg[2][0],
                                             pt_reg[2][1], pt_reg[2][6], pt_reg[2][7])) ||
                (ori[3] == ORI_COL && in_box(pt_reg[2][4], pt_reg[2][5], pt_reg[2][2],
                                             pt_reg[2][3], pt_reg[2][6], pt_reg[2][7]));
    end

    logic                  vld3_reg;
    logic                  touch3_reg;
    logic signed [VW-1:0]  c1_reg;
    logic signed [VW-1:0]  c2_reg;
    logic signed [VW-1:0]  det3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            touch3_reg <= touch;
            c1_reg     <= m_reg[0] + m_reg[1];
            c2_reg     <= m_reg[2] + m_reg[3];
            det3_reg   <= m_reg[4] - m_reg[5];
            ab_reg[3]  <= ab_reg[2];
            pt_reg[3]  <= pt_reg[2];
            zz_reg[3]  <= zz_reg[2];
        end
    end

    // stage 4
    logic                  vld4_reg;
    logic                  touch4_reg;
    logic signed [MW-1:0]  pr_reg [4];
    logic signed [VW-1:0]  det4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld4_reg <= 1'b0;
        end
        else if (en)
        begin
            vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            touch4_reg   <= touch3_reg;
            pr_reg[0]    <= ab_reg[3][3] * c1_reg;
            pr_reg[1]    <= ab_reg[3][1] * c2_reg;
            pr_reg[2]    <= ab_reg[3][0] * c2_reg;
            pr_reg[3]    <= ab_reg[3][2] * c1_reg;
            det4_reg     <= det3_reg;
            px_reg[4][0] <= pt_reg[3][0];
            px_reg[4][1] <= pt_reg[3][2];
            zz_reg[4]    <= zz_reg[3];
        end
    end

    // stage 5
    logic                  vld5_reg;
    logic                  ok5_reg;
    logic signed [NW-1:0]  nx5_reg;
    logic signed [NW-1:0]  ny5_reg;
    logic signed [VW-1:0]  det5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld5_reg <= 1'b0;
        end
        else if (en)
        begin
            vld5_reg <= vld4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok5_reg   <= touch4_reg && (det4_reg != '0);
            nx5_reg   <= pr_reg[0] - pr_reg[1];
            ny5_reg   <= pr_reg[2] - pr_reg[3];
            det5_reg  <= det4_reg;
            px_reg[5] <= px_reg[4];
            zz_reg[5] <= zz_reg[4];
        end
    end

    assign out_vld = vld5_reg;
    assign ok      = ok5_reg;
    assign num_x   = nx5_reg;
    assign num_y   = ny5_reg;
    assign det     = det5_reg;
    assign p1x     = px_reg[5][0];
    assign q1x     = px_reg[5][1];
    assign z0      = zz_reg[5][0];
    assign z1      = zz_reg[5][1];

endmodule

`default_nettype wire

@@ hw/rtl/sid_div.sv @@
// Pipelined restoring divider, truncating toward zero, one quotient bit per stage.
`default_nettype none

module sid_div #(
    parameter int NW = 44,
    parameter int DW = 29,
    parameter int QW = 13,
    parameter int SW = 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_vld,
    input  wire logic signed [NW-1:0]  num,
    input  wire logic signed [DW-1:0]  den,
    input  wire logic [SW-1:0]         side_in,
    output logic                       out_vld,
    output logic signed [QW:0]         quo,
    output logic [SW-1:0]              side_out
);
    localparam int EW = (NW > DW + QW) ? NW : DW + QW;

    logic signed [EW-1:0]  num_ext;
    logic signed [DW-1:0]  den_neg;
    logic [EW-1:0]         num_mag;
    logic [DW-1:0]         den_mag;

    always_comb
    begin
        num_ext = EW'(num);
        den_neg = -den;
        num_mag = num_ext[EW-1] ? EW'(-num_ext) : EW'(num_ext);
        den_mag = den[DW-1] ? den_neg : den;
    end

    logic              vld_reg  [0:QW];
    logic [EW-1:0]     rem_reg  [0:QW];
    logic [DW-1:0]     dv_reg   [0:QW];
    logic [QW-1:0]     q_reg    [0:QW];
    logic              neg_reg  [0:QW];
    logic [SW-1:0]     side_reg [0:QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num_mag;
            dv_reg[0]   <= den_mag;
            q_reg[0]    <= '0;
            neg_reg[0]  <= num[NW-1] ^ den[DW-1];
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_step
        logic [EW-1:0] trial;
        logic          take;
        logic [EW-1:0] rem_next;
        logic [QW-1:0] q_next;

        always_comb
        begin
            trial    = EW'(dv_reg[k-1]) << (QW - k);
            take     = rem_reg[k-1] >= trial;
            rem_next = take ? rem_reg[k-1] - trial : rem_reg[k-1];
            q_next   = q_reg[k-1] | (take ? (QW'(1) << (QW - k)) : '0);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                dv_reg[k]   <= dv_reg[k-1];
                q_reg[k]    <= q_next;
                neg_reg[k]  <= neg_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    logic signed [QW:0] q_pos;

    always_comb
    begin
        q_pos = {1'b0, q_reg[QW]};
        quo   = neg_reg[QW] ? -q_pos : q_pos;
    end

    assign out_vld  = vld_reg[QW];
    assign side_out = side_reg[QW];

endmodule

`default_nettype wire

@@ tb/sv/segment_intersection_with_depth_top_tb.sv @@
// Testbench for the segment intersection with depth block: directed and random segment pairs.
`default_nettype none

module segment_intersection_with_depth_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 13;
    localparam int DW = 16;
    localparam int LATENCY = CW + DW + 11;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        logic signed [DW-1:0] az0, az1;
    } seg_pair_t;

    typedef struct {
        logic hit;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [DW-1:0] z;
    } crossing_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [CW-1:0] a_start_x = '0, a_start_y = '0, a_end_x = '0, a_end_y = '0;
    logic signed [CW-1:0] b_start_x = '0, b_start_y = '0, b_end_x = '0, b_end_y = '0;
    logic signed [DW-1:0] a_start_z = '0, a_end_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic hit;
    logic signed [CW-1:0] cross_x, cross_y;
    logic signed [DW-1:0] cross_z;

    crossing_t expected_crossings[$];
    int mismatches = 0;
    int pairs_sent = 0;
    int hits_seen = 0;
    int results_seen = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    longint cycles = 0;

    segment_intersection_with_depth_top #(.COORD_BITS(CW), .DEPTH_BITS(DW)) u_top (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .a_start_x(a_start_x), .a_start_y(a_start_y), .a_start_z(a_start_z),
        .a_end_x(a_end_x), .a_end_y(a_end_y), .a_end_z(a_end_z),
        .b_start_x(b_start_x), .b_start_y(b_start_y),
        .b_end_x(b_end_x), .b_end_y(b_end_y),
        .out_valid(out_valid), .out_ready(out_ready), .hit(hit),
        .cross_x(cross_x), .cross_y(cross_y), .cross_z(cross_z)
    );

    always #6 clk = ~clk;

    function automatic int turn_of(longint px, longint py, longint qx, longint qy,
                                   longint rx, longint ry);
        longint v;
        v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
        if (v == 0) return 0;
        return (v > 0) ? 1 : 2;
    endfunction

    function automatic bit in_box(longint px, longint py, longint qx, longint qy,
                                  longint rx, longint ry);
        return qx <= ((px > rx) ? px : rx) && qx >= ((px < rx) ? px : rx) &&
               qy <= ((py > ry) ? py : ry) && qy >= ((py < ry) ? py : ry);
    endfunction

    function automatic longint sat(longint v, int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic crossing_t predict_crossing(seg_pair_t s);
        crossing_t r;
        longint p1x, p1y, q1x, q1y, p2x, p2y, q2x, q2y, z0, z1;
        longint a1, b1, c1, a2, b2, c2, det, x, y, z;
        int o1, o2, o3, o4;
        bit touch;
        r = '{1'b0, '0, '0, '0};
        p1x = s.ax0; p1y = s.ay0; q1x = s.ax1; q1y = s.ay1;
        p2x = s.bx0; p2y = s.by0; q2x = s.bx1; q2y = s.by1;
        z0 = s.az0; z1 = s.az1;
        o1 = turn_of(p1x, p1y, q1x, q1y, p2x, p2y);
        o2 = turn_of(p1x, p1y, q1x, q1y, q2x, q2y);
        o3 = turn_of(p2x, p2y, q2x, q2y, p1x, p1y);
        o4 = turn_of(p2x, p2y, q2x, q2y, q1x, q1y);
        touch = (o1 != o2 && o3 != o4) ||
                (o1 == 0 && in_box(p1x, p1y, p2x, p2y, q1x, q1y)) ||
                (o2 == 0 && in_box(p1x, p1y, q2x, q2y, q1x, q1y)) ||
                (o3 == 0 && in_box(p2x, p2y, p1x, p1y, q2x, q2y)) ||
                (o4 == 0 && in_box(p2x, p2y, q1x, q1y, q2x, q2y));
        if (!touch) return r;
        a1 = q1y - p1y; b1 = p1x - q1x; c1 = a1 * p1x + b1 * p1y;
        a2 = q2y - p2y; b2 = p2x - q2x; c2 = a2 * p2x + b2 * p2y;
        det = a1 * b2 - a2 * b1;
        if (det == 0) return r;
        x = (b2 * c1 - b1 * c2) / det;
        y = (a1 * c2 - a2 * c1) / det;
        if (z0 == z1 || q1x == p1x) z = z0;
        else z = z0 + ((z1 - z0) * (x - p1x)) / (q1x - p1x);
        r.hit = 1'b1;
        r.x = CW'(sat(x, CW));
        r.y = CW'(sat(y, CW));
        r.z = DW'(sat(z, DW));
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    task automatic send_pair(seg_pair_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        a_start_x <= s.ax0; a_start_y <= s.ay0; a_start_z <= s.az0;
        a_end_x <= s.ax1; a_end_y <= s.ay1; a_end_z <= s.az1;
        b_start_x <= s.bx0; b_start_y <= s.by0; b_end_x <= s.bx1; b_end_y <= s.by1;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        expected_crossings.insert(expected_crossings.size(), predict_crossing(s));
        pairs_sent++;
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rst_n) out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        crossing_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_crossings.size() == 0)
            begin
                report_mismatch("unexpected transaction", hit, 0);
            end
            else
            begin
                e = expected_crossings.pop_front();
                if (hit) hits_seen++;
                if (hit !== e.hit) report_mismatch("hit", hit, e.hit);
                if (cross_x !== e.x) report_mismatch("cross_x", cross_x, e.x);
                if (cross_y !== e.y) report_mismatch("cross_y", cross_y, e.y);
                if (cross_z !== e.z) report_mismatch("cross_z", cross_z, e.z);
            end
        end
    end

    function automatic logic signed [CW-1:0] rc(int span);
        if (span <= 0) return CW'($urandom);
        return CW'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic seg_pair_t mk(int ax0, int ay0, int az0, int ax1, int ay1, int az1,
                                     int bx0, int by0, int bx1, int by1);
        seg_pair_t s;
        s.ax0 = CW'(ax0); s.ay0 = CW'(ay0); s.az0 = DW'(az0);
        s.ax1 = CW'(ax1); s.ay1 = CW'(ay1); s.az1 = DW'(az1);
        s.bx0 = CW'(bx0); s.by0 = CW'(by0); s.bx1 = CW'(bx1); s.by1 = CW'(by1);
        return s;
    endfunction

    task automatic test_directed();
        send_pair(mk(-10, 0, 100, 10, 0, 200, 0, -10, 0, 10));
        send_pair(mk(0, -10, 100, 0, 10, 300, -10, 0, 10, 0));
        send_pair(mk(0, 0, 5, 10, 0, 5, 3, -4, 7, 4));
        send_pair(mk(0, 0, 0, 10, 0, 0, 0, 5, 10, 5));
        send_pair(mk(0, 0, 0, 10, 0, 9, 5, 0, 20, 0));
        send_pair(mk(0, 0, 0, 10, 10, 9, 10, 10, 20, 0));
        send_pair(mk(0, 0, 0, 10, 0, 9, 20, -5, 20, 5));
        send_pair(mk(-4096, -4096, -32768, 4095, 4095, 32767, -4096, 4095, 4095, -4096));
        send_pair(mk(-4096, 0, 32767, -4095, 0, -32768, -4096, -4096, -4095, 4095));
        send_pair(mk(-4096, 0, -32768, 4095, 1, 32767, 4095, -4096, -4096, 4095));
        send_pair(mk(4095, 4095, 32767, 4095, 4095, -32768, 4095, 4095, 0, 0));
        send_pair(mk(0, 0, 1, 0, 0, 2, 0, 0, 0, 0));
        send_pair(mk(-1, -1, -1, -1, -1, -1, -1, 4095, -1, -4096));
        send_pair(mk(1, 0, 0, 4, 3, 32767, 0, 3, 3, 0));
        send_pair(mk(-3, 1, 7, 2, -2, -9, -3, -2, 3, 2));
        send_pair(mk(0, 0, -32768, 8000, 7, 32767, 4000, -4096, 4001, 4095));
    endtask

    task automatic test_random(int n);
        seg_pair_t s;
        int span, mode;
        repeat (n)
        begin
            mode = $urandom_range(9);
            span = (mode < 3) ? 0 : (mode < 7) ? 40 : 4;
            s.ax0 = rc(span); s.ay0 = rc(span); s.ax1 = rc(span); s.ay1 = rc(span);
            s.bx0 = rc(span); s.by0 = rc(span); s.bx1 = rc(span); s.by1 = rc(span);
            s.az0 = DW'($urandom);
            s.az1 = ($urandom_range(5) == 0) ? s.az0 : DW'($urandom);
            if ($urandom_range(9) == 0) s.ax1 = s.ax0;
            if ($urandom_range(9) == 0)
            begin
                s.bx0 = s.ax0; s.by0 = s.ay0;
            end
            send_pair(s);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_crossings.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 30; recv_idle_pct = 88;
        test_directed();
        test_random(580);
        send_idle_pct = 88; recv_idle_pct = 30;
        test_random(580);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(640);
        drain();
        $display("covered %0d segment pairs, %0d results, %0d hits",
                 pairs_sent, results_seen, hits_seen);
        if (mismatches == 0 && expected_crossings.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

`default_nettype wire

@@ segment_intersection_with_depth_top.f @@
hw/rtl/sid_pkg.sv
hw/rtl/sid_geom.sv
hw/rtl/sid_div.sv
hw/rtl/segment_intersection_with_depth_top.sv
tb/sv/segment_intersection_with_depth_top_tb.sv
